### rtl/dmr_pkg.sv
// ----------------------------------------------------------------------------
// dmr_pkg
// Shared types and constants of the disc mask rasterizer: beat payloads,
// opcodes, register indexes, datapath commands and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package dmr_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int COORD_W   = 32;
    localparam int STEP_W    = 31;
    localparam int NUM_W     = 34;   // signed numerators of the bound divisions
    localparam int MAG_W     = 33;   // their magnitude
    localparam int ARG_W     = 62;   // square root argument
    localparam int ROOT_W    = 31;
    localparam int BITS_W    = 64;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_STEP_X   = 3'd2,
        CFG_STEP_Y   = 3'd3,
        CFG_COLS     = 3'd4,
        CFG_ROWS     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [STEP_W-1:0]         radius;
        logic [5:0]                column_index;
    } req_t;

    typedef struct packed {
        logic [BITS_W-1:0] column_bits;
        logic              touched;
    } rsp_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLR_STEP,
        DP_LATCH,
        DP_RD_COL,
        DP_CLR_COL,
        DP_DIV_JHI,
        DP_DIV_JLO,
        DP_MUL_R2,
        DP_MUL_JSX,
        DP_SET_DX,
        DP_MUL_DX,
        DP_SQRT,
        DP_DIV_IHI,
        DP_DIV_ILO,
        DP_COL_READ,
        DP_COL_WRITE,
        DP_COL_NEXT,
        DP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       clr_last;
        logic       div_done;
        logic       sqrt_done;
        logic       grid_empty;
        logic       cols_miss;
        logic       rows_miss;
        logic       last_col;
        logic       idx_ok;
        logic       out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_JHI_WAIT,
        ST_JLO,
        ST_JLO_WAIT,
        ST_COLS_CHK,
        ST_MUL_JSX,
        ST_SET_DX,
        ST_COL_SQ,
        ST_SQRT,
        ST_SQRT_WAIT,
        ST_IHI,
        ST_IHI_WAIT,
        ST_ILO,
        ST_ILO_WAIT,
        ST_ROWS_CHK,
        ST_COL_WR,
        ST_COL_NEXT,
        ST_DONE
    } ctrl_state_t;

endpackage

`default_nettype wire

### rtl/disc_mask_rasterizer.sv
// Read, clear and unused opcodes go from ST_IDLE through ST_DISPATCH to
// ST_DONE, which loads the result beat. Draw: the bit-serial divider runs
// twice for the column bounds, then, for each column in the clipped range,
// the square root once and the divider twice. One item at a time; a new
// item is accepted while the previous result beat still waits in the output
// register. After reset a clearing pass zeroes the mask column by column.
// ----------------------------------------------------------------------------
// disc_mask_rasterizer
// Binary pixel mask stored column by column; draws filled discs given in
// Q16.16, reads and clears single columns.
// ----------------------------------------------------------------------------
`default_nettype none

module disc_mask_rasterizer #(
    parameter int MAX_COLS = dmr_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = dmr_pkg::MAX_ROWS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dmr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dmr_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire dmr_pkg::req_t                 req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output dmr_pkg::rsp_t                      rsp
);

    dmr_pkg::dp_op_t     op;
    dmr_pkg::dp_status_t status;

    dmr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .op        (op)
    );

    dmr_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .op        (op),
        .status    (status),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

endmodule

`default_nettype wire

### rtl/dmr_div.sv
// ----------------------------------------------------------------------------
// dmr_div
// Restoring divider, one quotient bit per cycle, unsigned magnitude by a
// positive step value. Gives quotient and a nonzero-remainder flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dmr_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dmr_pkg::MAG_W-1:0]  num_mag,
    input  wire logic [dmr_pkg::STEP_W-1:0] divisor,
    output logic      [dmr_pkg::MAG_W-1:0]  quot,
    output logic                            rem_nz,
    output logic                            done
);

    localparam int MW = dmr_pkg::MAG_W;
    localparam int SW = dmr_pkg::STEP_W;
    localparam int CW = $clog2(MW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [MW-1:0] qn_reg;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] d_reg;

    logic [SW:0]   trial;
    logic [SW:0]   diff;
    logic          ge;
    logic [SW-1:0] rem_next;
    logic [MW-1:0] qn_next;

    assign trial    = {rem_reg, qn_reg[MW-1]};
    assign diff     = trial - {1'b0, d_reg};
    assign ge       = trial >= {1'b0, d_reg};
    assign rem_next = ge ? diff[SW-1:0] : trial[SW-1:0];
    assign qn_next  = {qn_reg[MW-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(MW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            qn_reg  <= num_mag;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            qn_reg  <= qn_next;
            rem_reg <= rem_next;
        end
    end

    assign quot   = qn_reg;
    assign rem_nz = rem_reg != '0;
    assign done   = done_reg;

endmodule

`default_nettype wire

### rtl/dmr_sqrt.sv
// ----------------------------------------------------------------------------
// dmr_sqrt
// Digit-by-digit integer square root (floor), one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmr_sqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dmr_pkg::ARG_W-1:0]  arg,
    output logic      [dmr_pkg::ROOT_W-1:0] root,
    output logic                            done
);

    localparam int AW = dmr_pkg::ARG_W;
    localparam int RW = dmr_pkg::ROOT_W;
    localparam int CW = $clog2(RW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] a_reg;
    logic [RW+1:0] rem_reg;
    logic [RW-1:0] root_reg;

    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    assign cur   = {rem_reg, a_reg[AW-1:AW-2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(RW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= arg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg    <= {a_reg[AW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW+1:0] : cur[RW+1:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### rtl/dmr_dp.sv
// ----------------------------------------------------------------------------
// dmr_dp
// Datapath: configuration registers, latched request, shared multiplier,
// divider and square root units, column bound registers, mask memory and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmr_dp #(
    parameter int MAX_COLS = dmr_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = dmr_pkg::MAX_ROWS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [dmr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dmr_pkg::CFG_W-1:0]     cfg_data,
    input  wire dmr_pkg::req_t                 req,
    input  wire dmr_pkg::dp_op_t               op,
    output dmr_pkg::dp_status_t                status,
    output dmr_pkg::rsp_t                      rsp,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NW = dmr_pkg::NUM_W;
    localparam int MW = dmr_pkg::MAG_W;
    localparam int SW = dmr_pkg::STEP_W;
    localparam int XW = 43;   // origin plus column offset before trimming
    localparam int DW = 33;   // signed dx, bounded by the radius

    // configuration
    logic signed [31:0] ox_reg;
    logic signed [31:0] oy_reg;
    logic [SW-1:0]      sx_reg;
    logic [SW-1:0]      sy_reg;
    logic [6:0]         cols_reg;
    logic [6:0]         rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg   <= '0;
            oy_reg   <= '0;
            sx_reg   <= SW'(65536);
            sy_reg   <= SW'(65536);
            cols_reg <= 7'd64;
            rows_reg <= 7'd64;
        end
        else if (cfg_wr_en)
        begin
            case (dmr_pkg::cfg_idx_t'(cfg_index))
                dmr_pkg::CFG_ORIGIN_X: ox_reg   <= cfg_data;
                dmr_pkg::CFG_ORIGIN_Y: oy_reg   <= cfg_data;
                dmr_pkg::CFG_STEP_X:   sx_reg   <= cfg_data[SW-1:0];
                dmr_pkg::CFG_STEP_Y:   sy_reg   <= cfg_data[SW-1:0];
                dmr_pkg::CFG_COLS:     cols_reg <= cfg_data[6:0];
                dmr_pkg::CFG_ROWS:     rows_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [SW-1:0]        sx_eff;
    logic [SW-1:0]        sy_eff;
    logic signed [NW-1:0] ncols;
    logic signed [NW-1:0] nrows;
    logic signed [NW-1:0] ncols_m1;
    logic signed [NW-1:0] nrows_m1;

    assign sx_eff   = (sx_reg == '0) ? SW'(1) : sx_reg;
    assign sy_eff   = (sy_reg == '0) ? SW'(1) : sy_reg;
    assign ncols    = ({{(NW-7){1'b0}}, cols_reg} > NW'(MAX_COLS)) ? NW'(MAX_COLS)
                                                                   : {{(NW-7){1'b0}}, cols_reg};
    assign nrows    = ({{(NW-7){1'b0}}, rows_reg} > NW'(MAX_ROWS)) ? NW'(MAX_ROWS)
                                                                   : {{(NW-7){1'b0}}, rows_reg};
    assign ncols_m1 = ncols - NW'(1);
    assign nrows_m1 = nrows - NW'(1);

    // latched request
    dmr_pkg::req_t req_reg;
    logic [15:0]   idx_wide;
    logic [AW-1:0] idx_addr;
    logic          idx_ok;

    assign idx_wide = {10'b0, req_reg.column_index};
    assign idx_addr = idx_wide[AW-1:0];
    assign idx_ok   = idx_wide < 16'(MAX_COLS);

    logic signed [NW-1:0] cx_s;
    logic signed [NW-1:0] cy_s;
    logic signed [NW-1:0] ox_s;
    logic signed [NW-1:0] oy_s;
    logic signed [NW-1:0] r_s;
    logic signed [NW-1:0] cyrel;

    assign cx_s  = {{(NW-32){req_reg.center_x[31]}}, req_reg.center_x};
    assign cy_s  = {{(NW-32){req_reg.center_y[31]}}, req_reg.center_y};
    assign ox_s  = {{(NW-32){ox_reg[31]}}, ox_reg};
    assign oy_s  = {{(NW-32){oy_reg[31]}}, oy_reg};
    assign r_s   = {{(NW-SW){1'b0}}, req_reg.radius};
    assign cyrel = cy_s - oy_s;

    // bound divisions
    logic [dmr_pkg::ROOT_W-1:0] dy_reg;
    logic signed [NW-1:0]       dy_s;
    logic signed [NW-1:0]       num;
    logic signed [NW-1:0]       num_abs;
    logic                       num_ceil;
    logic [SW-1:0]              div_d;
    logic                       div_start;
    logic [MW-1:0]              quot;
    logic                       rem_nz;
    logic                       div_done;

    assign dy_s = {{(NW-dmr_pkg::ROOT_W){1'b0}}, dy_reg};

    always_comb
    begin
        num       = '0;
        num_ceil  = 1'b0;
        div_d     = sx_eff;
        div_start = 1'b0;
        case (op)
            dmr_pkg::DP_DIV_JHI:
            begin
                num       = cx_s + r_s - ox_s;
                div_start = 1'b1;
            end
            dmr_pkg::DP_DIV_JLO:
            begin
                num       = cx_s - r_s - ox_s;
                num_ceil  = 1'b1;
                div_start = 1'b1;
            end
            dmr_pkg::DP_DIV_IHI:
            begin
                num       = cyrel + dy_s;
                div_d     = sy_eff;
                div_start = 1'b1;
            end
            dmr_pkg::DP_DIV_ILO:
            begin
                num       = cyrel - dy_s;
                num_ceil  = 1'b1;
                div_d     = sy_eff;
                div_start = 1'b1;
            end
            default: ;
        endcase
    end

    assign num_abs = num[NW-1] ? -num : num;

    dmr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (num_abs[MW-1:0]),
        .divisor (div_d),
        .quot    (quot),
        .rem_nz  (rem_nz),
        .done    (div_done)
    );

    logic            neg_reg;
    logic            ceil_reg;
    dmr_pkg::dp_op_t dest_reg;

    // floor and ceil from magnitude quotient and remainder flag
    logic signed [NW-1:0] q_s;
    logic signed [NW-1:0] q_up;
    logic signed [NW-1:0] div_res;

    assign q_s  = {1'b0, quot};
    assign q_up = q_s + NW'(rem_nz);

    always_comb
    begin
        if (neg_reg)
            div_res = ceil_reg ? -q_s : -q_up;
        else
            div_res = ceil_reg ? q_up : q_s;
    end

    logic signed [NW-1:0] jhi_reg;
    logic signed [NW-1:0] jlo_reg;
    logic signed [NW-1:0] ihi_reg;
    logic signed [NW-1:0] ilo_reg;

    // shared multiplier
    logic [AW-1:0]        j_reg;
    logic [AW-1:0]        jend_reg;
    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dx_neg;
    logic [31:0]          dx_abs;
    logic [31:0]          mul_a;
    logic [31:0]          mul_b;
    logic [63:0]          prod;
    logic [63:0]          mul_reg;
    logic [63:0]          r2_reg;

    assign dx_neg = -dx_reg;
    assign dx_abs = dx_reg[DW-1] ? dx_neg[31:0] : dx_reg[31:0];

    always_comb
    begin
        mul_a = dx_abs;
        mul_b = dx_abs;
        case (op)
            dmr_pkg::DP_MUL_R2:
            begin
                mul_a = {1'b0, req_reg.radius};
                mul_b = {1'b0, req_reg.radius};
            end
            dmr_pkg::DP_MUL_JSX:
            begin
                mul_a = {{(32-AW){1'b0}}, j_reg};
                mul_b = {1'b0, sx_eff};
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;

    logic [AW-1:0] jlo_c;
    logic [AW-1:0] jhi_c;
    logic [RW-1:0] ilo_c;
    logic [RW-1:0] ihi_c;

    assign jlo_c = jlo_reg[NW-1] ? '0 : jlo_reg[AW-1:0];
    assign jhi_c = (jhi_reg > ncols_m1) ? ncols_m1[AW-1:0] : jhi_reg[AW-1:0];
    assign ilo_c = ilo_reg[NW-1] ? '0 : ilo_reg[RW-1:0];
    assign ihi_c = (ihi_reg > nrows_m1) ? nrows_m1[RW-1:0] : ihi_reg[RW-1:0];

    logic signed [XW-1:0] dx_wide;

    assign dx_wide = {{(XW-32){ox_reg[31]}}, ox_reg} + {1'b0, mul_reg[XW-2:0]}
                   - {{(XW-32){req_reg.center_x[31]}}, req_reg.center_x};

    logic [dmr_pkg::ARG_W-1:0] sq_arg;
    logic [63:0]               arg_diff;
    logic                      sqrt_start;
    logic [dmr_pkg::ROOT_W-1:0] root;
    logic                      sqrt_done;

    assign arg_diff   = r2_reg - mul_reg;
    assign sq_arg     = (mul_reg > r2_reg) ? '0 : arg_diff[dmr_pkg::ARG_W-1:0];
    assign sqrt_start = op == dmr_pkg::DP_SQRT;

    dmr_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .arg   (sq_arg),
        .root  (root),
        .done  (sqrt_done)
    );

    // row span of the current column
    logic [MAX_ROWS-1:0] row_bits;
    logic [MAX_ROWS-1:0] bits_reg;

    assign row_bits = ({MAX_ROWS{1'b1}} >> (RW'(MAX_ROWS - 1) - ihi_c))
                    & ({MAX_ROWS{1'b1}} << ilo_c);

    // mask memory
    logic [MAX_ROWS-1:0] mask_mem [MAX_COLS];
    logic [MAX_ROWS-1:0] rd_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [MAX_ROWS-1:0] mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = j_reg;
        case (op)
            dmr_pkg::DP_CLR_STEP:
                mem_we = 1'b1;
            dmr_pkg::DP_CLR_COL:
            begin
                mem_we    = idx_ok;
                mem_waddr = idx_addr;
            end
            dmr_pkg::DP_COL_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = rd_reg | bits_reg;
            end
            dmr_pkg::DP_RD_COL:
            begin
                mem_re    = idx_ok;
                mem_raddr = idx_addr;
            end
            dmr_pkg::DP_COL_READ:
                mem_re = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mask_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_reg <= mask_mem[mem_raddr];
    end

    // control state
    logic touched_reg;
    logic rsp_valid_reg;
    logic out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            touched_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == dmr_pkg::DP_CLR_STEP)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (op == dmr_pkg::DP_LATCH)
                touched_reg <= 1'b0;
            else if (op == dmr_pkg::DP_COL_WRITE)
                touched_reg <= 1'b1;
            if (op == dmr_pkg::DP_OUT_LOAD)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers
    dmr_pkg::rsp_t rsp_reg;

    always_ff @(posedge clk)
    begin
        if (op == dmr_pkg::DP_LATCH)
            req_reg <= req;
        if (div_start)
        begin
            neg_reg  <= num[NW-1];
            ceil_reg <= num_ceil;
            dest_reg <= op;
        end
        if (div_done)
        begin
            case (dest_reg)
                dmr_pkg::DP_DIV_JHI: jhi_reg <= div_res;
                dmr_pkg::DP_DIV_JLO: jlo_reg <= div_res;
                dmr_pkg::DP_DIV_IHI: ihi_reg <= div_res;
                dmr_pkg::DP_DIV_ILO: ilo_reg <= div_res;
                default: ;
            endcase
        end
        if (sqrt_done)
            dy_reg <= root;
        case (op)
            dmr_pkg::DP_MUL_R2:
            begin
                r2_reg   <= prod;
                j_reg    <= jlo_c;
                jend_reg <= jhi_c;
            end
            dmr_pkg::DP_MUL_JSX,
            dmr_pkg::DP_MUL_DX:
                mul_reg <= prod;
            dmr_pkg::DP_SET_DX:
                dx_reg <= dx_wide[DW-1:0];
            dmr_pkg::DP_COL_READ:
                bits_reg <= row_bits;
            dmr_pkg::DP_COL_NEXT:
            begin
                j_reg  <= j_reg + 1'b1;
                dx_reg <= dx_reg + {2'b00, sx_eff};
            end
            dmr_pkg::DP_OUT_LOAD:
            begin
                rsp_reg.column_bits <= (req_reg.opcode == dmr_pkg::OP_READ && idx_ok)
                                       ? dmr_pkg::BITS_W'(rd_reg) : '0;
                rsp_reg.touched     <= touched_reg;
            end
            default: ;
        endcase
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    assign status.opcode     = req_reg.opcode;
    assign status.clr_last   = clr_cnt_reg == AW'(MAX_COLS - 1);
    assign status.div_done   = div_done;
    assign status.sqrt_done  = sqrt_done;
    assign status.grid_empty = (ncols == '0) || (nrows == '0);
    assign status.cols_miss  = jhi_reg[NW-1] || (jlo_reg >= ncols) || (jhi_reg < jlo_reg);
    assign status.rows_miss  = ihi_reg[NW-1] || (ilo_reg >= nrows) || (ihi_reg < ilo_reg);
    assign status.last_col   = j_reg == jend_reg;
    assign status.idx_ok     = idx_ok;
    assign status.out_free   = out_free;

endmodule

`default_nettype wire

### rtl/dmr_ctrl.sv
// ----------------------------------------------------------------------------
// dmr_ctrl
// Controller: sequences the clearing pass, read and clear items, and the
// column loop of a draw, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire dmr_pkg::dp_status_t status,
    output dmr_pkg::dp_op_t          op
);

    dmr_pkg::ctrl_state_t state_reg;
    dmr_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dmr_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op         = dmr_pkg::DP_NOP;
        req_stall  = 1'b1;
        case (state_reg)
            dmr_pkg::ST_CLEAR:
            begin
                op = dmr_pkg::DP_CLR_STEP;
                if (status.clr_last)
                    state_next = dmr_pkg::ST_IDLE;
            end
            dmr_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    op         = dmr_pkg::DP_LATCH;
                    state_next = dmr_pkg::ST_DISPATCH;
                end
            end
            dmr_pkg::ST_DISPATCH:
            begin
                state_next = dmr_pkg::ST_DONE;
                case (status.opcode)
                    dmr_pkg::OP_DRAW:
                    begin
                        if (!status.grid_empty)
                        begin
                            op         = dmr_pkg::DP_DIV_JHI;
                            state_next = dmr_pkg::ST_JHI_WAIT;
                        end
                    end
                    dmr_pkg::OP_READ:  op = dmr_pkg::DP_RD_COL;
                    dmr_pkg::OP_CLEAR: op = dmr_pkg::DP_CLR_COL;
                    default: ;
                endcase
            end
            dmr_pkg::ST_JHI_WAIT:
                if (status.div_done)
                    state_next = dmr_pkg::ST_JLO;
            dmr_pkg::ST_JLO:
            begin
                op         = dmr_pkg::DP_DIV_JLO;
                state_next = dmr_pkg::ST_JLO_WAIT;
            end
            dmr_pkg::ST_JLO_WAIT:
                if (status.div_done)
                    state_next = dmr_pkg::ST_COLS_CHK;
            dmr_pkg::ST_COLS_CHK:
            begin
                if (status.cols_miss)
                    state_next = dmr_pkg::ST_DONE;
                else
                begin
                    op         = dmr_pkg::DP_MUL_R2;
                    state_next = dmr_pkg::ST_MUL_JSX;
                end
            end
            dmr_pkg::ST_MUL_JSX:
            begin
                op         = dmr_pkg::DP_MUL_JSX;
                state_next = dmr_pkg::ST_SET_DX;
            end
            dmr_pkg::ST_SET_DX:
            begin
                op         = dmr_pkg::DP_SET_DX;
                state_next = dmr_pkg::ST_COL_SQ;
            end
            dmr_pkg::ST_COL_SQ:
            begin
                op         = dmr_pkg::DP_MUL_DX;
                state_next = dmr_pkg::ST_SQRT;
            end
            dmr_pkg::ST_SQRT:
            begin
                op         = dmr_pkg::DP_SQRT;
                state_next = dmr_pkg::ST_SQRT_WAIT;
            end
            dmr_pkg::ST_SQRT_WAIT:
                if (status.sqrt_done)
                    state_next = dmr_pkg::ST_IHI;
            dmr_pkg::ST_IHI:
            begin
                op         = dmr_pkg::DP_DIV_IHI;
                state_next = dmr_pkg::ST_IHI_WAIT;
            end
            dmr_pkg::ST_IHI_WAIT:
                if (status.div_done)
                    state_next = dmr_pkg::ST_ILO;
            dmr_pkg::ST_ILO:
            begin
                op         = dmr_pkg::DP_DIV_ILO;
                state_next = dmr_pkg::ST_ILO_WAIT;
            end
            dmr_pkg::ST_ILO_WAIT:
                if (status.div_done)
                    state_next = dmr_pkg::ST_ROWS_CHK;
            dmr_pkg::ST_ROWS_CHK:
            begin
                if (status.rows_miss)
                    state_next = dmr_pkg::ST_COL_NEXT;
                else
                begin
                    op         = dmr_pkg::DP_COL_READ;
                    state_next = dmr_pkg::ST_COL_WR;
                end
            end
            dmr_pkg::ST_COL_WR:
            begin
                op         = dmr_pkg::DP_COL_WRITE;
                state_next = dmr_pkg::ST_COL_NEXT;
            end
            dmr_pkg::ST_COL_NEXT:
            begin
                if (status.last_col)
                    state_next = dmr_pkg::ST_DONE;
                else
                begin
                    op         = dmr_pkg::DP_COL_NEXT;
                    state_next = dmr_pkg::ST_COL_SQ;
                end
            end
            dmr_pkg::ST_DONE:
            begin
                // hold until the result register can take the beat
                if (status.out_free)
                begin
                    op         = dmr_pkg::DP_OUT_LOAD;
                    state_next = dmr_pkg::ST_IDLE;
                end
            end
            default:
                state_next = dmr_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### rtl/dmr_checker.sv
// ----------------------------------------------------------------------------
// dmr_checker
// Port-level checks of the disc mask rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dmr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cfg_wr_en,
    input wire logic [dmr_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [dmr_pkg::CFG_W-1:0]     cfg_data,
    input wire logic                          req_valid,
    input wire logic                          req_stall,
    input wire dmr_pkg::req_t                 req,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_stall,
    input wire dmr_pkg::rsp_t                 rsp
);

    logic       req_acc;
    logic       rsp_acc;
    logic [1:0] pend_reg;

    assign req_acc = req_valid && !req_stall;
    assign rsp_acc = rsp_valid && !rsp_stall;

    // items accepted whose result beat is not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (req_acc && !rsp_acc)
            pend_reg <= pend_reg + 1'b1;
        else if (rsp_acc && !req_acc)
            pend_reg <= pend_reg - 1'b1;
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result beat without an accepted item");

    a_one_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> req_stall)
        else $error("third item accepted before results drained");

    a_touched_draw: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.touched |-> rsp.column_bits == '0)
        else $error("touched set on a result carrying column bits");

    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> req_stall && !rsp_valid)
        else $error("item taken during clearing pass");

endmodule

bind disc_mask_rasterizer dmr_checker u_dmr_checker (.*);

`default_nettype wire

### test/disc_mask_rasterizer_test.sv
// ----------------------------------------------------------------------------
// disc_mask_rasterizer_test
// Self-checking bench for the disc mask rasterizer. A model of the column
// mask predicts every result beat. Directed draws, reads and clears come
// first, then random traffic under several grid settings, then a long
// output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module disc_mask_rasterizer_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint     Q_ONE     = 65536;
    localparam longint     COORD_MIN = -64'sd2147483648;
    localparam longint     COORD_MAX = 64'sd2147483647;
    localparam int         HOLD_CYCLES = 400;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [dmr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dmr_pkg::CFG_W-1:0]     cfg_data;
    logic                          req_valid;
    logic                          req_stall;
    dmr_pkg::req_t                 req;
    logic                          rsp_valid;
    logic                          rsp_stall;
    dmr_pkg::rsp_t                 rsp;

    // model of the block
    logic [63:0] mask_model [64];
    longint      org_x, org_y, pitch_x, pitch_y, cols_cfg, rows_cfg;

    dmr_pkg::rsp_t rsp_due_q [$];
    int   errors;
    int   burst_left;
    bit   hold_start;
    int   hold_left;
    int   stall_mode;
    int   mode_left;

    disc_mask_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("disc_mask_rasterizer: mismatch");
        $finish;
    end

    function automatic longint div_down(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q--;
        return q;
    endfunction

    function automatic longint div_up(longint n, longint d);
        return -div_down(-n, d);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned rem, root, b;
        rem  = n;
        root = 0;
        b    = 64'h4000_0000_0000_0000;
        while (b > rem)
            b >>= 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  -= root + b;
                root  = (root >> 1) + b;
            end
            else
            begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic longint eff_pitch(longint p);
        return (p == 0) ? 1 : p;
    endfunction

    function automatic longint eff_count(longint c);
        return (c > 64) ? 64 : c;
    endfunction

    function automatic bit rasterize_disc(longint cx, longint cy, longint r);
        longint      sx, sy, nc, nr, jlo, jhi, j, cyrel, r2, dx, arg, dy, ilo, ihi;
        bit          hit;
        logic [63:0] bits;
        sx  = eff_pitch(pitch_x);
        sy  = eff_pitch(pitch_y);
        nc  = eff_count(cols_cfg);
        nr  = eff_count(rows_cfg);
        hit = 0;
        if (nc <= 0 || nr <= 0)
            return 0;
        jhi = div_down(cx + r - org_x, sx);
        jlo = div_up(cx - r - org_x, sx);
        if (jhi < 0 || jlo >= nc || jhi < jlo)
            return 0;
        if (jlo < 0)
            jlo = 0;
        if (jhi > nc - 1)
            jhi = nc - 1;
        r2    = r * r;
        cyrel = cy - org_y;
        for (j = jlo; j <= jhi; j++)
        begin
            dx  = org_x + j * sx - cx;
            arg = r2 - dx * dx;
            if (arg < 0)
                arg = 0;
            dy  = longint'(root_floor($unsigned(arg)));
            ihi = div_down(cyrel + dy, sy);
            ilo = div_up(cyrel - dy, sy);
            if (ihi < 0 || ilo >= nr || ihi < ilo)
                continue;
            if (ilo < 0)
                ilo = 0;
            if (ihi > nr - 1)
                ihi = nr - 1;
            bits = ({64{1'b1}} >> (63 - ihi)) & ({64{1'b1}} << ilo);
            mask_model[j] |= bits;
            hit = 1;
        end
        return hit;
    endfunction

    function automatic dmr_pkg::rsp_t predict_rsp(dmr_pkg::req_t it);
        dmr_pkg::rsp_t o;
        o = '0;
        case (it.opcode)
            dmr_pkg::OP_DRAW:
                o.touched = rasterize_disc(longint'(it.center_x), longint'(it.center_y),
                                           longint'({1'b0, it.radius}));
            dmr_pkg::OP_READ:  o.column_bits = mask_model[it.column_index];
            dmr_pkg::OP_CLEAR: mask_model[it.column_index] = '0;
            default:  ;
        endcase
        return o;
    endfunction

    function automatic dmr_pkg::req_t make_req(logic [1:0] op, longint cx, longint cy,
                                               longint r, int idx);
        dmr_pkg::req_t it;
        it.opcode       = op;
        it.center_x     = cx[31:0];
        it.center_y     = cy[31:0];
        it.radius       = r[30:0];
        it.column_index = idx[5:0];
        return it;
    endfunction

    // draws land mostly on the grid with radii of a couple of pitches
    function automatic dmr_pkg::req_t random_req();
        dmr_pkg::req_t it;
        int     pick;
        longint sx, sy, cx, cy, r;
        sx   = eff_pitch(pitch_x);
        sy   = eff_pitch(pitch_y);
        pick = $urandom_range(0, 99);
        it   = make_req(dmr_pkg::OP_DRAW, longint'($urandom), longint'($urandom),
                        longint'($urandom), $urandom_range(0, 63));
        if (pick < 42)
        begin
            if ($urandom_range(0, 39) != 0)
            begin
                cx = org_x + longint'($urandom_range(0, 64)) * sx
                     + longint'($urandom) % (sx + 1) - sx / 2;
                cy = org_y + longint'($urandom_range(0, 64)) * sy
                     + longint'($urandom) % (sy + 1) - sy / 2;
                r  = longint'($urandom) % (2 * sx + 1);
                if (r > COORD_MAX)
                    r = COORD_MAX;
                it.center_x = cx[31:0];
                it.center_y = cy[31:0];
                it.radius   = r[30:0];
            end
        end
        else if (pick < 72)
            it.opcode = dmr_pkg::OP_READ;
        else if (pick < 96)
            it.opcode = dmr_pkg::OP_CLEAR;
        else
            it.opcode = OP_UNUSED;
        return it;
    endfunction

    task automatic send_req(dmr_pkg::req_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (req_stall);
        rsp_due_q.push_back(predict_rsp(it));
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (rsp_due_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(dmr_pkg::cfg_idx_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            dmr_pkg::CFG_ORIGIN_X: org_x    = longint'($signed(value));
            dmr_pkg::CFG_ORIGIN_Y: org_y    = longint'($signed(value));
            dmr_pkg::CFG_STEP_X:   pitch_x  = longint'(value[30:0]);
            dmr_pkg::CFG_STEP_Y:   pitch_y  = longint'(value[30:0]);
            dmr_pkg::CFG_COLS:     cols_cfg = longint'(value[6:0]);
            dmr_pkg::CFG_ROWS:     rows_cfg = longint'(value[6:0]);
            default:      ;
        endcase
    endtask

    task automatic set_grid(longint ox, longint oy, longint sx, longint sy, int nc, int nr);
        drain();
        write_reg(dmr_pkg::CFG_ORIGIN_X, ox[31:0]);
        write_reg(dmr_pkg::CFG_ORIGIN_Y, oy[31:0]);
        write_reg(dmr_pkg::CFG_STEP_X, sx[31:0]);
        write_reg(dmr_pkg::CFG_STEP_Y, sy[31:0]);
        write_reg(dmr_pkg::CFG_COLS, nc);
        write_reg(dmr_pkg::CFG_ROWS, nr);
    endtask

    task automatic run_random(int count);
        repeat (count) send_req(random_req());
    endtask

    task automatic test_directed();
        send_req(make_req(dmr_pkg::OP_READ, 0, 0, 0, 0));
        send_req(make_req(dmr_pkg::OP_READ, 0, 0, 0, 63));
        // zero radius exactly on a pixel centre
        send_req(make_req(dmr_pkg::OP_DRAW, 0, 0, 0, 0));
        send_req(make_req(dmr_pkg::OP_DRAW, 10 * Q_ONE, 10 * Q_ONE,
                          3 * Q_ONE + Q_ONE / 2, 0));
        send_req(make_req(dmr_pkg::OP_READ, 0, 0, 0, 10));
        send_req(make_req(dmr_pkg::OP_READ, 0, 0, 0, 13));
        send_req(make_req(dmr_pkg::OP_CLEAR, 0, 0, 0, 10));
        send_req(make_req(dmr_pkg::OP_READ, 0, 0, 0, 10));
        send_req(make_req(OP_UNUSED, -1, -1, COORD_MAX, 63));
        // fully outside the grid on each side
        send_req(make_req(dmr_pkg::OP_DRAW, -100 * Q_ONE, 5 * Q_ONE, 2 * Q_ONE, 0));
        send_req(make_req(dmr_pkg::OP_DRAW, 5 * Q_ONE, 200 * Q_ONE, 2 * Q_ONE, 0));
        send_req(make_req(dmr_pkg::OP_DRAW, COORD_MIN, COORD_MIN, 5 * Q_ONE, 0));
        send_req(make_req(dmr_pkg::OP_DRAW, COORD_MAX, COORD_MAX, 5 * Q_ONE, 63));
        // disc hanging over the grid corner
        send_req(make_req(dmr_pkg::OP_DRAW, -Q_ONE, 63 * Q_ONE + 100, 3 * Q_ONE, 0));
        send_req(make_req(dmr_pkg::OP_READ, 0, 0, 0, 0));
        send_req(make_req(dmr_pkg::OP_READ, 0, 0, 0, 1));
        // largest radius covers the whole grid
        send_req(make_req(dmr_pkg::OP_DRAW, 32 * Q_ONE, 32 * Q_ONE, COORD_MAX, 0));
        send_req(make_req(dmr_pkg::OP_READ, 0, 0, 0, 63));
        send_req(make_req(dmr_pkg::OP_CLEAR, 0, 0, 0, 63));
        send_req(make_req(dmr_pkg::OP_READ, 0, 0, 0, 63));
        send_req(make_req(dmr_pkg::OP_READ, 0, 0, 0, 31));
    endtask

    task automatic test_pressure();
        drain();
        hold_start = 1'b1;
        repeat (40)
            send_req(make_req($urandom_range(0, 1) ? dmr_pkg::OP_READ : dmr_pkg::OP_CLEAR,
                              0, 0, 0, $urandom_range(0, 63)));
    endtask

    // output side: random stall stretches, quiet stretches, and one long hold
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(16, 200);
            end
            mode_left--;
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                default: rsp_stall <= $urandom_range(0, 1);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (rsp_due_q.size() == 0)
            begin
                $display("%0t: unexpected beat column_bits=%h touched=%b",
                         $time, rsp.column_bits, rsp.touched);
                errors++;
            end
            else
            begin
                if (rsp.column_bits !== rsp_due_q[0].column_bits)
                begin
                    $display("%0t: column_bits expected %h actual %h",
                             $time, rsp_due_q[0].column_bits, rsp.column_bits);
                    errors++;
                end
                if (rsp.touched !== rsp_due_q[0].touched)
                begin
                    $display("%0t: touched expected %b actual %b",
                             $time, rsp_due_q[0].touched, rsp.touched);
                    errors++;
                end
                void'(rsp_due_q.pop_front());
            end
        end
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        req_valid  = 1'b0;
        req        = '0;
        rsp_stall  = 1'b0;
        errors     = 0;
        burst_left = 0;
        hold_start = 1'b0;
        hold_left  = 0;
        stall_mode = 0;
        mode_left  = 0;
        foreach (mask_model[i])
            mask_model[i] = '0;
        org_x    = 0;
        org_y    = 0;
        pitch_x  = Q_ONE;
        pitch_y  = Q_ONE;
        cols_cfg = 64;
        rows_cfg = 64;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        set_grid(0, 0, Q_ONE, Q_ONE, 64, 64);
        run_random(600);
        set_grid(COORD_MIN, COORD_MAX, COORD_MAX, 1, 127, 127);
        run_random(150);
        set_grid(COORD_MAX, COORD_MIN, 0, 0, 1, 64);
        run_random(150);
        set_grid(0, 0, Q_ONE, Q_ONE, 0, 5);
        run_random(80);
        set_grid(0, 0, Q_ONE, Q_ONE, 64, 0);
        run_random(80);
        set_grid(-(7 * Q_ONE) / 2, (9 * Q_ONE) / 4, 'h18000, 'h0c000, 40, 64);
        run_random(600);
        set_grid(Q_ONE / 3, -Q_ONE, Q_ONE, Q_ONE, 64, 1);
        run_random(150);
        set_grid(0, 0, Q_ONE, Q_ONE, 64, 64);
        run_random(100);
        test_pressure();
        drain();

        if (errors == 0)
            $display("disc_mask_rasterizer: match");
        else
            $display("disc_mask_rasterizer: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
